@@ hw/rtl/fcc_pkg.sv @@
package fcc_pkg;

    // Default capacity of the adjacency store, in vertices.
    localparam int MAX_VERTICES_DEF = 64;

    localparam int COUNT_W = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_BEGIN = 2'd0;
    localparam logic [1:0] FUNC_EDGE  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] vertex_count;
        logic [5:0] vert_a;
        logic [5:0] vert_b;
    } fcc_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] clique_count;
        logic [1:0]         status;
    } fcc_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clear_graph;
        logic       latch_edge;
        logic       wr_a;
        logic       wr_b;
        logic       cnt_start;
        logic       load_ra;
        logic       next_a;
        logic       pick_b;
        logic       load_cab;
        logic       pick_c;
        logic       load_and;
        logic       add_cnt;
        logic       out_load;
        logic [1:0] out_code;
    } fcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic too_big;
        logic edge_bad;
        logic ra_zero;
        logic cab_zero;
        logic a_last;
        logic none_active;
    } fcc_stat_t;

endpackage

@@ hw/rtl/fcc_dpath.sv @@
module fcc_dpath #(
    parameter int MAX_VERTICES = fcc_pkg::MAX_VERTICES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fcc_pkg::fcc_in_t  item,
    input  fcc_pkg::fcc_cmd_t cmd,
    output fcc_pkg::fcc_stat_t stat,
    output fcc_pkg::fcc_out_t  result
);
    import fcc_pkg::*;

    localparam int W  = MAX_VERTICES;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = $clog2(MAX_VERTICES + 1);

    // Adjacency store: one row per vertex, one valid bit per row.
    logic [W-1:0] adj_mem [W];
    logic [W-1:0] row_valid_reg;

    logic [AW-1:0] active_reg;
    logic [5:0]    va_reg;
    logic [5:0]    vb_reg;
    logic [AW-1:0] a_reg;
    logic [W-1:0]  ra_reg;
    logic [W-1:0]  cab_reg;
    logic [W-1:0]  and_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [W-1:0]  rd_row_reg;
    logic          rd_ok_reg;
    fcc_out_t      result_reg;

    logic [VW-1:0] wr_addr;
    logic [VW-1:0] wr_bit;
    logic [VW-1:0] rd_addr;
    logic [VW-1:0] low_ra;
    logic [VW-1:0] low_cab;
    logic [W-1:0]  row;
    logic [W-1:0]  above_a;
    logic [AW-1:0] pc;
    logic [COUNT_W:0] sum;

    // Index of the lowest set bit of a row.
    function automatic logic [VW-1:0] lowest_idx(input logic [W-1:0] v);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

    // Number of set bits in a row.
    function automatic logic [AW-1:0] popcount(input logic [W-1:0] v);
        logic [AW-1:0] n;
        n = '0;
        for (int i = 0; i < W; i++) begin
            n = n + AW'(v[i]);
        end
        return n;
    endfunction

    // Checks on the incoming transaction and status flags for the counting walk.
    always_comb
    begin
        stat.too_big     = item.vertex_count > 8'(MAX_VERTICES);
        stat.edge_bad    = (8'(item.vert_a) >= 8'(active_reg)) ||
                           (8'(item.vert_b) >= 8'(active_reg));
        stat.ra_zero     = (ra_reg == '0);
        stat.cab_zero    = (cab_reg == '0);
        stat.a_last      = (AW'(a_reg + 1'b1) == active_reg);
        stat.none_active = (active_reg == '0);
    end

    // Write port: the first write of a row after a begin replaces the stale contents.
    assign wr_addr = cmd.wr_a ? VW'(va_reg) : VW'(vb_reg);
    assign wr_bit  = cmd.wr_a ? VW'(vb_reg) : VW'(va_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a || cmd.wr_b) begin
            if (row_valid_reg[wr_addr]) begin
                adj_mem[wr_addr][wr_bit] <= 1'b1;
            end else begin
                adj_mem[wr_addr] <= W'(1) << wr_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_valid_reg <= '0;
        end else if (cmd.clear_graph) begin
            row_valid_reg <= '0;
        end else if (cmd.wr_a || cmd.wr_b) begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Read port: the address follows the vertex being picked, else the outer vertex.
    assign low_ra  = lowest_idx(ra_reg);
    assign low_cab = lowest_idx(cab_reg);

    always_comb
    begin
        if (cmd.pick_b) begin
            rd_addr = low_ra;
        end else if (cmd.pick_c) begin
            rd_addr = low_cab;
        end else begin
            rd_addr = a_reg[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg <= adj_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_ok_reg <= 1'b0;
        end else begin
            rd_ok_reg <= row_valid_reg[rd_addr];
        end
    end

    assign row = rd_ok_reg ? rd_row_reg : '0;

    // Active vertex count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= '0;
        end else if (cmd.clear_graph) begin
            active_reg <= stat.too_big ? '0 : AW'(item.vertex_count);
        end
    end

    // Counting walk over vertex sets.
    assign above_a = ({W{1'b1}} << a_reg[VW-1:0]) << 1;
    assign pc      = popcount(and_reg);
    assign sum     = {1'b0, total_reg} + (COUNT_W + 1)'(pc);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_edge) begin
            va_reg <= item.vert_a;
            vb_reg <= item.vert_b;
        end
        if (cmd.cnt_start) begin
            a_reg     <= '0;
            total_reg <= '0;
        end else begin
            if (cmd.next_a) begin
                a_reg <= a_reg + 1'b1;
            end
            if (cmd.add_cnt) begin
                total_reg <= sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
            end
        end
        if (cmd.load_ra) begin
            ra_reg <= row & above_a;
        end else if (cmd.pick_b) begin
            ra_reg <= ra_reg & (ra_reg - 1'b1);
        end
        if (cmd.load_cab) begin
            cab_reg <= ra_reg & row;
        end else if (cmd.pick_c) begin
            cab_reg <= cab_reg & (cab_reg - 1'b1);
        end
        if (cmd.load_and) begin
            and_reg <= cab_reg & row;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load) begin
            result_reg.status       <= cmd.out_code;
            result_reg.clique_count <= (cmd.out_code == STATUS_OK) ? total_reg : '0;
        end
    end

    assign result = result_reg;

endmodule

@@ hw/rtl/fcc_ctrl.sv @@
module fcc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         func,
    output logic               result_valid,
    input  logic               result_ready,
    input  fcc_pkg::fcc_stat_t stat,
    output fcc_pkg::fcc_cmd_t  cmd
);
    import fcc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WR_A    = 4'd1;
    localparam logic [3:0] S_WR_B    = 4'd2;
    localparam logic [3:0] S_RD_A    = 4'd3;
    localparam logic [3:0] S_LD_RA   = 4'd4;
    localparam logic [3:0] S_NEXT_B  = 4'd5;
    localparam logic [3:0] S_LD_CAB  = 4'd6;
    localparam logic [3:0] S_NEXT_C  = 4'd7;
    localparam logic [3:0] S_LD_AND  = 4'd8;
    localparam logic [3:0] S_ADD     = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    // A new transaction is taken when idle and the result slot is free or freeing.
    assign item_ready   = (state_reg == S_IDLE) && (!out_valid_reg || result_ready);
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_code = STATUS_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    case (func)
                        FUNC_BEGIN:
                        begin
                            cmd.clear_graph = 1'b1;
                            if (stat.too_big) begin
                                cmd.out_load = 1'b1;
                                cmd.out_code = STATUS_TOO_BIG;
                            end
                        end
                        FUNC_EDGE:
                        begin
                            if (stat.edge_bad) begin
                                cmd.out_load = 1'b1;
                                cmd.out_code = STATUS_RANGE;
                            end else begin
                                cmd.latch_edge = 1'b1;
                                state_next     = S_WR_A;
                            end
                        end
                        FUNC_END:
                        begin
                            cmd.cnt_start = 1'b1;
                            state_next    = stat.none_active ? S_DONE : S_RD_A;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WR_A:
            begin
                cmd.wr_a   = 1'b1;
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                cmd.wr_b   = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_A:
            begin
                state_next = S_LD_RA;
            end
            S_LD_RA:
            begin
                cmd.load_ra = 1'b1;
                state_next  = S_NEXT_B;
            end
            S_NEXT_B:
            begin
                if (!stat.ra_zero) begin
                    cmd.pick_b = 1'b1;
                    state_next = S_LD_CAB;
                end else if (stat.a_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.next_a = 1'b1;
                    state_next = S_RD_A;
                end
            end
            S_LD_CAB:
            begin
                cmd.load_cab = 1'b1;
                state_next   = S_NEXT_C;
            end
            S_NEXT_C:
            begin
                if (stat.cab_zero) begin
                    state_next = S_NEXT_B;
                end else begin
                    cmd.pick_c = 1'b1;
                    state_next = S_LD_AND;
                end
            end
            S_LD_AND:
            begin
                cmd.load_and = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_cnt = 1'b1;
                state_next  = S_NEXT_C;
            end
            S_DONE:
            begin
                cmd.out_load = 1'b1;
                cmd.out_code = STATUS_OK;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag: a new result wins over a completed transaction.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/four_clique_counter.sv @@
// Four-vertex clique counter.
// Input channel item/item_valid/item_ready carries commands: begin (func 0) sets the
// vertex count and empties the graph, edge (func 1) adds an undirected edge, end
// (func 2) counts the complete four-vertex subgraphs. Output channel
// result/result_valid/result_ready returns a count with status 0, or an error status
// for a begin above MAX_VERTICES or an edge endpoint outside the vertex count.
// A begin clears the graph as it is accepted; an edge is accepted and then written to
// the adjacency memory once per direction (S_WR_A, S_WR_B): it has a single write port.
// An end walks the graph one memory read at a time: for each vertex S_RD_A, S_LD_RA;
// for each adjacent higher pair S_NEXT_B, S_LD_CAB; for each common neighbor S_NEXT_C,
// S_LD_AND, S_ADD; then S_DONE. The single read port of the memory sets this order.
// Error results appear in the cycle after the transaction is accepted.
// Reset empties the graph at once (per-row valid bits) and sets the vertex count to
// zero, so an edge before any begin is out of range. While a result waits for
// result_ready, item_ready stays low, so no new transaction is accepted until the
// result is taken, which may happen in the same cycle as the next acceptance.
module four_clique_counter #(
    parameter int MAX_VERTICES = fcc_pkg::MAX_VERTICES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  fcc_pkg::fcc_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output fcc_pkg::fcc_out_t result
);
    import fcc_pkg::*;

    fcc_cmd_t  cmd;
    fcc_stat_t stat;

    // Sequencer.
    fcc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (item.func),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Adjacency store and counting datapath.
    fcc_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import fcc_pkg::*;

    // Encoding that the block must ignore without a result.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 950;
    localparam int DRAIN_CYCLES = 50;

    // Keeps a copy of the graph, predicts the result of every accepted
    // transaction and checks the results in order.
    class clique_scoreboard;
        logic [fcc_pkg::MAX_VERTICES_DEF-1:0] adj_rows [fcc_pkg::MAX_VERTICES_DEF];
        int unsigned live_vertices;
        fcc_out_t awaited_q [$];
        int mismatches;
        int items_taken;
        int counts_checked;
        int errors_checked;
        int unsigned top_count;

        function new();
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            live_vertices = 0;
            mismatches = 0;
            items_taken = 0;
            counts_checked = 0;
            errors_checked = 0;
            top_count = 0;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // Number of four-vertex cliques among the live vertices, saturated.
        function int unsigned count_k4();
            logic [fcc_pkg::MAX_VERTICES_DEF-1:0] one_bit;
            logic [fcc_pkg::MAX_VERTICES_DEF-1:0] span;
            logic [fcc_pkg::MAX_VERTICES_DEF-1:0] ab;
            logic [fcc_pkg::MAX_VERTICES_DEF-1:0] abc;
            int unsigned total;
            int n;
            one_bit = 1;
            total = 0;
            n = (live_vertices > fcc_pkg::MAX_VERTICES_DEF) ?
                fcc_pkg::MAX_VERTICES_DEF : live_vertices;
            span = (one_bit << n) - 1;
            for (int a = 0; a < n; a++)
            begin
                for (int b = a + 1; b < n; b++)
                begin
                    if (adj_rows[a][b])
                    begin
                        ab = adj_rows[a] & adj_rows[b] & span;
                        for (int c = b + 1; c < n; c++)
                        begin
                            if (ab[c])
                            begin
                                // Only fourth vertices above c, so each set counts once.
                                abc = ab & adj_rows[c] & ~((one_bit << (c + 1)) - 1);
                                total += $countones(abc);
                            end
                        end
                    end
                end
            end
            if (total > COUNT_MAX)
                total = COUNT_MAX;
            return total;
        endfunction

        // Update the graph copy and queue any predicted result for one accepted transaction.
        function void note_item(fcc_in_t t);
            fcc_out_t r;
            items_taken++;
            r.clique_count = '0;
            r.status = STATUS_OK;
            case (t.func)
                FUNC_BEGIN:
                begin
                    foreach (adj_rows[i])
                        adj_rows[i] = '0;
                    if (t.vertex_count > fcc_pkg::MAX_VERTICES_DEF)
                    begin
                        live_vertices = 0;
                        r.status = STATUS_TOO_BIG;
                        awaited_q.push_back(r);
                    end
                    else
                        live_vertices = t.vertex_count;
                end
                FUNC_EDGE:
                begin
                    if (t.vert_a >= live_vertices || t.vert_b >= live_vertices)
                    begin
                        r.status = STATUS_RANGE;
                        awaited_q.push_back(r);
                    end
                    else
                    begin
                        adj_rows[t.vert_a][t.vert_b] = 1'b1;
                        adj_rows[t.vert_b][t.vert_a] = 1'b1;
                    end
                end
                FUNC_END:
                begin
                    r.clique_count = COUNT_W'(count_k4());
                    awaited_q.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string what);
            $display("tb: mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(fcc_out_t got);
            fcc_out_t want;
            if (awaited_q.size() == 0)
            begin
                report($sformatf("result with nothing pending: count %0d status %0d",
                                 got.clique_count, got.status));
                return;
            end
            want = awaited_q.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d, predicted %0d", got.status, want.status));
            if (got.clique_count != want.clique_count)
                report($sformatf("clique_count %0d, predicted %0d",
                                 got.clique_count, want.clique_count));
            if (want.status == STATUS_OK)
                counts_checked++;
            else
                errors_checked++;
            if (want.clique_count > top_count)
                top_count = want.clique_count;
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_ready;
    fcc_in_t  item = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    fcc_out_t result;

    clique_scoreboard sb;
    fcc_in_t command_q [$];
    int commands_built = 0;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int mode_left = 0;
    int stall_hold = 0;

    four_clique_counter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic fcc_in_t make_item(logic [1:0] f, int nv, int a, int b);
        fcc_in_t t;
        t.func = f;
        t.vertex_count = nv[7:0];
        t.vert_a = a[5:0];
        t.vert_b = b[5:0];
        return t;
    endfunction

    task automatic queue_item(fcc_in_t t);
        command_q.push_back(t);
        if (t.func != FUNC_UNUSED)
            commands_built++;
    endtask

    // Edge with a random direction and a random unused count field.
    task automatic queue_edge(int a, int b);
        if ($urandom_range(0, 1))
            queue_item(make_item(FUNC_EDGE, $urandom_range(0, 255), b, a));
        else
            queue_item(make_item(FUNC_EDGE, $urandom_range(0, 255), a, b));
    endtask

    // One mostly well-formed graph: begin, a planted near-clique, extra edges, end.
    task automatic queue_graph();
        logic [63:0] used;
        int members [$];
        int pick;
        int n;
        int k;
        int v;
        int extra;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            n = $urandom_range(4, 12);
        else if (pick < 85)
            n = $urandom_range(13, 32);
        else if (pick < 90)
            n = $urandom_range(33, MAX_VERTICES_DEF);
        else if (pick < 95)
            n = $urandom_range(0, 3);
        else
            n = $urandom_range(MAX_VERTICES_DEF + 1, 255);
        queue_item(make_item(FUNC_BEGIN, n, $urandom_range(0, 63), $urandom_range(0, 63)));

        if (n > 0 && n <= MAX_VERTICES_DEF)
        begin
            // Planted group of vertices, most of its pairs joined.
            k = (n < 4) ? n : $urandom_range(4, (n < 7) ? n : 7);
            used = '0;
            while (members.size() < k)
            begin
                v = $urandom_range(0, n - 1);
                if (!used[v])
                begin
                    used[v] = 1'b1;
                    members.push_back(v);
                end
            end
            for (int i = 0; i < k; i++)
                for (int j = i + 1; j < k; j++)
                    if ($urandom_range(0, 9) != 0)
                        queue_edge(members[i], members[j]);
            extra = $urandom_range(0, (2 * n < 20) ? 2 * n : 20);
            for (int i = 0; i < extra; i++)
                queue_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
            if ($urandom_range(0, 6) == 0)
            begin
                v = $urandom_range(0, n - 1);
                queue_edge(v, v);
            end
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                queue_edge($urandom_range(0, 63), $urandom_range(0, 63));
        end

        // Occasional broken edge and ignored encoding inside the sequence.
        if ($urandom_range(0, 9) < 3)
            queue_edge($urandom_range(0, 63), $urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0)
            queue_item(make_item(FUNC_UNUSED, $urandom_range(0, 255),
                                 $urandom_range(0, 63), $urandom_range(0, 63)));
        queue_item(make_item(FUNC_END, $urandom_range(0, 255),
                             $urandom_range(0, 63), $urandom_range(0, 63)));
        if ($urandom_range(0, 4) == 0)
            queue_item(make_item(FUNC_END, $urandom_range(0, 255),
                                 $urandom_range(0, 63), $urandom_range(0, 63)));
    endtask

    // Fully random transactions between graphs.
    task automatic queue_noise();
        repeat ($urandom_range(1, 4))
            queue_item(make_item(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                                 $urandom_range(0, 63), $urandom_range(0, 63)));
    endtask

    // Drive one transaction from a falling edge until it is accepted.
    task automatic send_item(fcc_in_t t);
        item <= t;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(t);
        @(negedge clk);
    endtask

    // Receiver: stretches of always ready, light stalls, heavy stalls and long holds.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (stall_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= ($urandom_range(0, 3) != 0);
            2: result_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    result_ready <= 1'b0;
                end
                else
                begin
                    result_ready <= 1'b1;
                    stall_hold = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                end
            end
        endcase
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // Stimulus and end of run.
    initial
    begin
        int burst;
        int gap;
        sb = new();

        // Directed: edge and end before any begin, oversized begins.
        queue_item(make_item(FUNC_EDGE, 0, 0, 0));
        queue_item(make_item(FUNC_END, 0, 0, 0));
        queue_item(make_item(FUNC_BEGIN, 255, 63, 63));
        queue_item(make_item(FUNC_EDGE, 0, 1, 2));
        queue_item(make_item(FUNC_BEGIN, MAX_VERTICES_DEF + 1, 0, 0));
        // Full capacity with a clique on the top four vertices and a self loop.
        queue_item(make_item(FUNC_BEGIN, MAX_VERTICES_DEF, 0, 0));
        queue_item(make_item(FUNC_EDGE, 0, 60, 61));
        queue_item(make_item(FUNC_EDGE, 0, 62, 60));
        queue_item(make_item(FUNC_EDGE, 0, 60, 63));
        queue_item(make_item(FUNC_EDGE, 0, 61, 62));
        queue_item(make_item(FUNC_EDGE, 0, 63, 61));
        queue_item(make_item(FUNC_EDGE, 0, 62, 63));
        queue_item(make_item(FUNC_EDGE, 255, 63, 63));
        queue_item(make_item(FUNC_END, 0, 0, 0));
        queue_item(make_item(FUNC_END, 255, 63, 63));
        queue_item(make_item(FUNC_UNUSED, 255, 63, 63));
        // Smallest graph that can hold a clique, plus an endpoint just out of range.
        queue_item(make_item(FUNC_BEGIN, 4, 0, 0));
        queue_item(make_item(FUNC_EDGE, 0, 0, 1));
        queue_item(make_item(FUNC_EDGE, 0, 0, 2));
        queue_item(make_item(FUNC_EDGE, 0, 0, 3));
        queue_item(make_item(FUNC_EDGE, 0, 1, 2));
        queue_item(make_item(FUNC_EDGE, 0, 1, 3));
        queue_item(make_item(FUNC_EDGE, 0, 3, 2));
        queue_item(make_item(FUNC_EDGE, 0, 4, 0));
        queue_item(make_item(FUNC_END, 0, 0, 0));

        // Random: mostly well-formed graphs, some noise.
        commands_built = 0;
        while (commands_built < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 85)
                queue_graph();
            else
                queue_noise();
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Sender: bursts of random length with random gaps.
        while (command_q.size() > 0)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && command_q.size() > 0; i++)
                send_item(command_q.pop_front());
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        item_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d transactions accepted, %0d counts and %0d error statuses checked",
                 sb.items_taken, sb.counts_checked, sb.errors_checked);
        $display("summary: largest clique count %0d, %0d mismatches",
                 sb.top_count, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
